### design/ncis_pkg.sv
// ----------------------------------------------------------------------------
// ncis_pkg
// Shared types and constants of the nibble CPU instruction step core.
// ----------------------------------------------------------------------------
package ncis_pkg;

  localparam int STACK_DEPTH_DEF = 8;
  localparam int PAIR_COUNT_DEF  = 8;
  localparam int BASE_DEPTH      = 4;

  // opcode rows (upper nibble)
  localparam logic [3:0] ROW_JCN = 4'h1;
  localparam logic [3:0] ROW_FIM = 4'h2;
  localparam logic [3:0] ROW_JUN = 4'h4;
  localparam logic [3:0] ROW_JMS = 4'h5;
  localparam logic [3:0] ROW_INC = 4'h6;
  localparam logic [3:0] ROW_ADD = 4'h8;
  localparam logic [3:0] ROW_LD  = 4'hA;
  localparam logic [3:0] ROW_XCH = 4'hB;
  localparam logic [3:0] ROW_BBL = 4'hC;
  localparam logic [3:0] ROW_LDM = 4'hD;
  localparam logic [3:0] ROW_IO  = 4'hE;
  localparam logic [3:0] ROW_ACC = 4'hF;

  // I/O row subcodes
  localparam logic [3:0] IO_WMP = 4'h1;
  localparam logic [3:0] IO_RDR = 4'hA;

  // accumulator row subcodes
  localparam logic [3:0] ACC_CLB = 4'h0;
  localparam logic [3:0] ACC_CLC = 4'h1;
  localparam logic [3:0] ACC_RAL = 4'h5;
  localparam logic [3:0] ACC_RAR = 4'h6;
  localparam logic [3:0] ACC_DAC = 4'h8;

  // configuration register addresses
  localparam logic [1:0] ADDR_VARIANT = 2'd0;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] next_byte;
    logic [3:0] port_rd;
    logic       test;
  } ncis_item_t;

  typedef struct packed {
    logic [3:0] acc;
    logic       cy;
    logic [7:0] src;
  } ncis_arch_t;

  typedef struct packed {
    logic [11:0] pc_new;
    ncis_arch_t  arch;
    logic        pair_we;
    logic [7:0]  pair_wdata;
    logic        stk_we;
    logic [11:0] stk_wdata;
    logic        port_write;
    logic [3:0]  port_wdata;
    logic        illegal;
  } ncis_exec_out_t;

endpackage

### design/ncis_pair_ram.sv
// ----------------------------------------------------------------------------
// ncis_pair_ram
// Register-pair file: one write port, one registered read port with bypass.
// ----------------------------------------------------------------------------
module ncis_pair_ram #(
  parameter int PAIR_COUNT = ncis_pkg::PAIR_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic [$clog2(PAIR_COUNT)-1:0] waddr,
  input  logic [7:0]                    wdata,
  input  logic                          ren,
  input  logic [$clog2(PAIR_COUNT)-1:0] raddr,
  output logic [7:0]                    rdata
);

  logic [7:0]            mem [PAIR_COUNT];
  logic [PAIR_COUNT-1:0] vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      if (we && waddr == raddr) begin
        rdata <= wdata;
      end else if (vld[raddr]) begin
        rdata <= mem[raddr];
      end else begin
        rdata <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

endmodule

### design/ncis_stack_ram.sv
// ----------------------------------------------------------------------------
// ncis_stack_ram
// PC/return stack: one write port, two registered read ports with bypass.
// ----------------------------------------------------------------------------
module ncis_stack_ram #(
  parameter int STACK_DEPTH = ncis_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [$clog2(STACK_DEPTH)-1:0] waddr,
  input  logic [11:0]                    wdata,
  input  logic                           ren,
  input  logic [$clog2(STACK_DEPTH)-1:0] raddr_a,
  input  logic [$clog2(STACK_DEPTH)-1:0] raddr_b,
  output logic [11:0]                    rdata_a,
  output logic [11:0]                    rdata_b
);

  logic [11:0]            mem [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      if (we && waddr == raddr_a) begin
        rdata_a <= wdata;
      end else if (vld[raddr_a]) begin
        rdata_a <= mem[raddr_a];
      end else begin
        rdata_a <= '0;
      end
      if (we && waddr == raddr_b) begin
        rdata_b <= wdata;
      end else if (vld[raddr_b]) begin
        rdata_b <= mem[raddr_b];
      end else begin
        rdata_b <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

endmodule

### design/ncis_exec.sv
// ----------------------------------------------------------------------------
// ncis_exec
// Instruction decode and execute: next PC, accumulator, carry, source
// address, stack pointer and the write-back data for both memories.
// ----------------------------------------------------------------------------
module ncis_exec #(
  parameter int STACK_DEPTH = ncis_pkg::STACK_DEPTH_DEF
) (
  input  ncis_pkg::ncis_item_t           item,
  input  logic [7:0]                     pair_val,
  input  logic [11:0]                    pc_base,
  input  logic [11:0]                    ret_pc,
  input  ncis_pkg::ncis_arch_t           arch,
  input  logic [$clog2(STACK_DEPTH)-1:0] sp_cur,
  input  logic [$clog2(STACK_DEPTH):0]   depth,
  output logic [$clog2(STACK_DEPTH)-1:0] sp_new,
  output ncis_pkg::ncis_exec_out_t       xo
);

  localparam int SPW = $clog2(STACK_DEPTH);

  logic [3:0]  hi;
  logic [3:0]  lo;
  logic [11:0] pc1;
  logic [11:0] pc2;
  logic [3:0]  nib;
  logic [3:0]  nib_inc;
  logic [4:0]  add_sum;
  logic [4:0]  dac_sum;
  logic        jcn_cond;

  assign hi       = item.opcode[7:4];
  assign lo       = item.opcode[3:0];
  assign pc1      = pc_base + 12'd1;
  assign pc2      = pc_base + 12'd2;
  assign nib      = lo[0] ? pair_val[3:0] : pair_val[7:4];
  assign nib_inc  = nib + 4'd1;
  assign add_sum  = {1'b0, arch.acc} + {1'b0, nib} + {4'b0, arch.cy};
  assign dac_sum  = {1'b0, arch.acc} + 5'd15;
  assign jcn_cond = ((lo[2] && arch.acc == 4'd0) || (lo[1] && arch.cy) ||
                     (lo[0] && !item.test)) ^ lo[3];

  always_comb begin
    xo            = '0;
    xo.pc_new     = pc1;
    xo.arch       = arch;
    xo.stk_wdata  = pc1;
    xo.pair_wdata = item.next_byte;
    sp_new        = sp_cur;
    unique case (hi)
      ncis_pkg::ROW_JCN: begin
        xo.pc_new = jcn_cond ? {pc2[11:8], item.next_byte} : pc2;
      end
      ncis_pkg::ROW_FIM: begin
        if (lo[0]) begin
          xo.arch.src = pair_val;
        end else begin
          xo.pair_we = 1'b1;
          xo.pc_new  = pc2;
        end
      end
      ncis_pkg::ROW_JUN: begin
        xo.pc_new = {lo, item.next_byte};
      end
      ncis_pkg::ROW_JMS: begin
        xo.stk_we    = 1'b1;
        xo.stk_wdata = pc2;
        xo.pc_new    = {lo, item.next_byte};
        sp_new       = (({1'b0, sp_cur} + (SPW + 1)'(1)) == depth) ? '0 : sp_cur + 1'b1;
      end
      ncis_pkg::ROW_INC: begin
        xo.pair_we    = 1'b1;
        xo.pair_wdata = lo[0] ? {pair_val[7:4], nib_inc} : {nib_inc, pair_val[3:0]};
      end
      ncis_pkg::ROW_ADD: begin
        xo.arch.acc = add_sum[3:0];
        xo.arch.cy  = add_sum[4];
      end
      ncis_pkg::ROW_LD: begin
        xo.arch.acc = nib;
      end
      ncis_pkg::ROW_XCH: begin
        xo.pair_we    = 1'b1;
        xo.pair_wdata = lo[0] ? {pair_val[7:4], arch.acc} : {arch.acc, pair_val[3:0]};
        xo.arch.acc   = nib;
      end
      ncis_pkg::ROW_BBL: begin
        xo.stk_we   = 1'b1;
        xo.pc_new   = ret_pc;
        xo.arch.acc = lo;
        sp_new      = (sp_cur == '0) ? SPW'(depth - (SPW + 1)'(1)) : sp_cur - 1'b1;
      end
      ncis_pkg::ROW_LDM: begin
        xo.arch.acc = lo;
      end
      ncis_pkg::ROW_IO: begin
        unique case (lo)
          ncis_pkg::IO_WMP: begin
            xo.port_write = 1'b1;
            xo.port_wdata = arch.acc;
          end
          ncis_pkg::IO_RDR: xo.arch.acc = item.port_rd;
          default:          xo.illegal  = 1'b1;
        endcase
      end
      ncis_pkg::ROW_ACC: begin
        unique case (lo)
          ncis_pkg::ACC_CLB: begin
            xo.arch.acc = 4'd0;
            xo.arch.cy  = 1'b0;
          end
          ncis_pkg::ACC_CLC: xo.arch.cy = 1'b0;
          ncis_pkg::ACC_RAL: begin
            xo.arch.acc = {arch.acc[2:0], arch.cy};
            xo.arch.cy  = arch.acc[3];
          end
          ncis_pkg::ACC_RAR: begin
            xo.arch.acc = {arch.cy, arch.acc[3:1]};
            xo.arch.cy  = arch.acc[0];
          end
          ncis_pkg::ACC_DAC: begin
            xo.arch.acc = dac_sum[3:0];
            xo.arch.cy  = dac_sum[4];
          end
          default: xo.illegal = 1'b1;
        endcase
      end
      default: xo.illegal = 1'b1;
    endcase
  end

endmodule

### design/nibble_cpu_instruction_step_core.sv
// ----------------------------------------------------------------------------
// nibble_cpu_instruction_step_core
// One 4-bit CPU instruction per stream item, state held in two small RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_t*) carries one instruction per item: opcode byte, the
//   following program byte, the I/O port nibble and the test pin level.
//   Output stream (m_t*) returns exactly one item per instruction: next PC,
//   accumulator, carry, port write strobe, source address, port write data
//   and the illegal-opcode flag.
//   APB register 0 (cpu_variant) selects a 4-deep (0) or STACK_DEPTH-deep (1)
//   return stack; write it only while no instruction is in flight.
//   The pair file and the PC stack are read at the accepting edge; execute
//   and write-back into the output register follow when it is free.
//   Throughput: one instruction per cycle while m_tready is high. Reads
//   for the next item are issued with the stack pointer and write data of
//   the item in execute bypassed.
//   Reset clears all CPU state with no clearing pass: pairs and stack through
//   per-entry valid bits; pointer, accumulator, carry, source address directly.
//   When m_tready is low the result holds in the output register and one
//   more item is taken into the read stage before s_tready drops.
// ----------------------------------------------------------------------------
module nibble_cpu_instruction_step_core #(
  parameter int STACK_DEPTH = ncis_pkg::STACK_DEPTH_DEF,
  parameter int PAIR_COUNT  = ncis_pkg::PAIR_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // instruction items
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] opcode_byte, [15:8] next_byte, [19:16] port_read_data,
  // [20] test_level, [23:21] zero
  input  logic [23:0] s_tdata,
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  // [11:0] next_pc, [15:12] acc_value, [16] carry_value, [17] port_write,
  // [25:18] port_address, [29:26] port_write_data, [30] illegal_op, [31] zero
  output logic [31:0] m_tdata
);

  localparam int SPW = $clog2(STACK_DEPTH);
  localparam int PAW = $clog2(PAIR_COUNT);
  localparam logic [SPW:0] DEPTH_HI = (SPW + 1)'(STACK_DEPTH);
  localparam logic [SPW:0] DEPTH_LO = (SPW + 1)'(ncis_pkg::BASE_DEPTH);

  function automatic logic [SPW-1:0] wrap_sp(input logic [SPW-1:0] x,
                                             input logic [SPW:0] d);
    logic [SPW-1:0] r;
    r = x;
    if ({1'b0, x} >= d) begin
      r = x - d[SPW-1:0];
    end
    return r;
  endfunction

  logic                     cpu_variant;
  logic                     cfg_wr;
  logic                     cfg_var_wr;
  logic [SPW:0]             depth;

  logic                     s1_valid;
  ncis_pkg::ncis_item_t     s1_item;
  ncis_pkg::ncis_item_t     in_item;
  logic                     accept;
  logic                     exec_fire;

  ncis_pkg::ncis_arch_t     arch;
  logic [SPW-1:0]           sp;
  logic [11:0]              cur_pc;
  logic                     pc_cached;

  logic [SPW-1:0]           sp_cur;
  logic [SPW-1:0]           sp_new;
  logic [SPW-1:0]           sp_fwd;
  logic [SPW-1:0]           rd_a;
  logic [SPW-1:0]           rd_b;
  logic [11:0]              pc_base;
  logic [11:0]              stk_a;
  logic [11:0]              stk_b;
  logic [7:0]               pair_val;
  ncis_pkg::ncis_exec_out_t xo;

  logic                     stk_we;
  logic [SPW-1:0]           stk_waddr;
  logic [11:0]              stk_wdata;

  // configuration port
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign cfg_var_wr = cfg_wr && paddr == ncis_pkg::ADDR_VARIANT;
  assign prdata     = (paddr == ncis_pkg::ADDR_VARIANT) ? 32'(cpu_variant) : '0;
  assign depth      = cpu_variant ? DEPTH_HI : DEPTH_LO;

  // handshake
  assign exec_fire = s1_valid && (!m_tvalid || m_tready);
  assign s_tready  = !s1_valid || exec_fire;
  assign accept    = s_tvalid && s_tready;

  assign in_item.opcode    = s_tdata[7:0];
  assign in_item.next_byte = s_tdata[15:8];
  assign in_item.port_rd   = s_tdata[19:16];
  assign in_item.test      = s_tdata[20];

  // read addresses for the incoming item, stack pointer bypassed from execute
  assign sp_cur = wrap_sp(sp, depth);
  assign sp_fwd = wrap_sp(exec_fire ? sp_new : sp, depth);
  assign rd_a   = sp_fwd;
  assign rd_b   = (sp_fwd == '0) ? SPW'(depth - (SPW + 1)'(1)) : sp_fwd - 1'b1;

  // stack write: return address from execute, or top-of-stack sync on config
  assign stk_we    = (exec_fire && xo.stk_we) || cfg_var_wr;
  assign stk_waddr = exec_fire ? sp_cur : sp;
  assign stk_wdata = exec_fire ? xo.stk_wdata : cur_pc;

  assign pc_base = pc_cached ? cur_pc : stk_a;

  ncis_pair_ram #(
    .PAIR_COUNT(PAIR_COUNT)
  ) u_pair_ram (
    .clk  (clk),
    .rst  (rst),
    .we   (exec_fire && xo.pair_we),
    .waddr(PAW'(s1_item.opcode[3:1])),
    .wdata(xo.pair_wdata),
    .ren  (accept),
    .raddr(PAW'(in_item.opcode[3:1])),
    .rdata(pair_val)
  );

  ncis_stack_ram #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk    (clk),
    .rst    (rst),
    .we     (stk_we),
    .waddr  (stk_waddr),
    .wdata  (stk_wdata),
    .ren    (accept),
    .raddr_a(rd_a),
    .raddr_b(rd_b),
    .rdata_a(stk_a),
    .rdata_b(stk_b)
  );

  ncis_exec #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_exec (
    .item    (s1_item),
    .pair_val(pair_val),
    .pc_base (pc_base),
    .ret_pc  (stk_b),
    .arch    (arch),
    .sp_cur  (sp_cur),
    .depth   (depth),
    .sp_new  (sp_new),
    .xo      (xo)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
    end
    if (exec_fire) begin
      m_tdata <= {1'b0, xo.illegal, xo.port_wdata, xo.arch.src, xo.port_write,
                  xo.arch.cy, xo.arch.acc, xo.pc_new};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_variant <= 1'b0;
      s1_valid    <= 1'b0;
      m_tvalid    <= 1'b0;
      arch        <= '0;
      sp          <= '0;
      cur_pc      <= '0;
      pc_cached   <= 1'b1;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (exec_fire) begin
        s1_valid <= 1'b0;
      end
      if (exec_fire) begin
        m_tvalid  <= 1'b1;
        arch      <= xo.arch;
        sp        <= sp_new;
        cur_pc    <= xo.pc_new;
        pc_cached <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_var_wr) begin
        cpu_variant <= pwdata[0];
        pc_cached   <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_sp_in_range: assert property (@(posedge clk) disable iff (rst)
    exec_fire |=> ({1'b0, sp} < $past(depth)))
    else $error("stack pointer outside active depth after execute");

  a_sp_moves_with_push: assert property (@(posedge clk) disable iff (rst)
    exec_fire && (sp_new != sp_cur) |-> xo.stk_we)
    else $error("stack pointer moved without a stack write");

  a_illegal_no_write: assert property (@(posedge clk) disable iff (rst)
    exec_fire && xo.illegal |-> !xo.pair_we && !xo.stk_we && !xo.port_write)
    else $error("illegal opcode changed stored state");

  a_exec_to_output: assert property (@(posedge clk) disable iff (rst)
    exec_fire |=> m_tvalid)
    else $error("executed item did not reach the output register");
`endif

endmodule

### dv/tb_nibble_cpu_instruction_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nibble_cpu_instruction_step_core
// Self-checking bench for the nibble CPU instruction step core.
// Instructions go in on the input stream with bursty timing. Each one is
// executed on a shadow copy of the CPU state when it is accepted, and every
// output item is compared field by field with the oldest predicted step.
// The stack depth register is changed between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_nibble_cpu_instruction_step_core;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_PRINTS     = 40;

  typedef struct packed {
    logic        pad;
    logic        illegal;
    logic [3:0]  port_wdata;
    logic [7:0]  port_addr;
    logic        port_wr;
    logic        cy;
    logic [3:0]  acc;
    logic [11:0] pc;
  } step_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  // shadow CPU state
  logic [7:0]  pairs [ncis_pkg::PAIR_COUNT_DEF];
  logic [11:0] ret_stack [ncis_pkg::STACK_DEPTH_DEF];
  int unsigned stk_ptr;
  logic [3:0]  acc_q;
  logic        cy_q;
  logic [7:0]  src_q;
  logic        variant_q;

  step_result_t expected_steps [$];
  int errors;

  int  burst_left;
  bit  tx_gaps;
  bit  rx_free;
  int  rx_phase;
  int  rx_period;
  int  rx_low;
  int  hold_req;
  int  hold_seq;
  int  hold_seen;
  int  hold_left;
  int  idle_cycles;

  nibble_cpu_instruction_step_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < MAX_PRINTS)
      $display("ERROR @%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic [3:0] reg_nibble(input logic [3:0] r);
    return r[0] ? pairs[r[3:1]][3:0] : pairs[r[3:1]][7:4];
  endfunction

  task automatic put_nibble(input logic [3:0] r, input logic [3:0] v);
    if (r[0])
      pairs[r[3:1]][3:0] = v;
    else
      pairs[r[3:1]][7:4] = v;
  endtask

  task automatic reset_shadow();
    foreach (pairs[i]) pairs[i] = '0;
    foreach (ret_stack[i]) ret_stack[i] = '0;
    stk_ptr   = 0;
    acc_q     = '0;
    cy_q      = 1'b0;
    src_q     = '0;
    variant_q = 1'b0;
  endtask

  task automatic execute_instr(input logic [7:0] op, input logic [7:0] nb,
                               input logic [3:0] prd, input logic tst);
    int unsigned  depth;
    int unsigned  sp;
    logic [3:0]   hi;
    logic [3:0]   lo;
    logic [3:0]   t4;
    logic [11:0]  pc;
    logic [4:0]   sum;
    logic         taken;
    logic         old_cy;
    logic         wr;
    logic         bad;
    step_result_t r;
    depth  = variant_q ? ncis_pkg::STACK_DEPTH_DEF : ncis_pkg::BASE_DEPTH;
    sp     = stk_ptr % depth;
    hi     = op[7:4];
    lo     = op[3:0];
    pc     = ret_stack[sp] + 12'd1;
    old_cy = cy_q;
    wr     = 1'b0;
    bad    = 1'b0;
    case (hi)
      ncis_pkg::ROW_JCN: begin
        pc = pc + 12'd1;
        taken = (lo[2] && acc_q == 4'd0) || (lo[1] && cy_q) || (lo[0] && !tst);
        if (lo[3]) taken = !taken;
        if (taken) pc = {pc[11:8], nb};
      end
      ncis_pkg::ROW_FIM: begin
        if (lo[0]) begin
          src_q = pairs[lo[3:1]];
        end else begin
          pairs[lo[3:1]] = nb;
          pc = pc + 12'd1;
        end
      end
      ncis_pkg::ROW_JUN: pc = {lo, nb};
      ncis_pkg::ROW_JMS: begin
        pc = pc + 12'd1;
        ret_stack[sp] = pc;
        sp = (sp + 1) % depth;
        pc = {lo, nb};
      end
      ncis_pkg::ROW_INC: put_nibble(lo, reg_nibble(lo) + 4'd1);
      ncis_pkg::ROW_ADD: begin
        sum   = 5'(acc_q) + 5'(reg_nibble(lo)) + 5'(cy_q);
        cy_q  = sum[4];
        acc_q = sum[3:0];
      end
      ncis_pkg::ROW_LD: acc_q = reg_nibble(lo);
      ncis_pkg::ROW_XCH: begin
        t4 = reg_nibble(lo);
        put_nibble(lo, acc_q);
        acc_q = t4;
      end
      ncis_pkg::ROW_BBL: begin
        ret_stack[sp] = pc;
        sp = (sp + depth - 1) % depth;
        pc = ret_stack[sp];
        acc_q = lo;
      end
      ncis_pkg::ROW_LDM: acc_q = lo;
      ncis_pkg::ROW_IO: begin
        if (lo == ncis_pkg::IO_WMP)
          wr = 1'b1;
        else if (lo == ncis_pkg::IO_RDR)
          acc_q = prd;
        else
          bad = 1'b1;
      end
      ncis_pkg::ROW_ACC: begin
        case (lo)
          ncis_pkg::ACC_CLB: begin
            acc_q = '0;
            cy_q = 1'b0;
          end
          ncis_pkg::ACC_CLC: cy_q = 1'b0;
          ncis_pkg::ACC_RAL: begin
            cy_q = acc_q[3];
            acc_q = {acc_q[2:0], old_cy};
          end
          ncis_pkg::ACC_RAR: begin
            cy_q = acc_q[0];
            acc_q = {old_cy, acc_q[3:1]};
          end
          ncis_pkg::ACC_DAC: begin
            sum   = 5'(acc_q) + 5'd15;
            cy_q  = sum[4];
            acc_q = sum[3:0];
          end
          default: bad = 1'b1;
        endcase
      end
      default: bad = 1'b1;
    endcase
    stk_ptr       = sp;
    ret_stack[sp] = pc;
    r.pad        = 1'b0;
    r.illegal    = bad;
    r.port_wdata = wr ? acc_q : 4'd0;
    r.port_addr  = src_q;
    r.port_wr    = wr;
    r.cy         = cy_q;
    r.acc        = acc_q;
    r.pc         = pc;
    expected_steps.push_back(r);
  endtask

  task automatic send_instr(input logic [7:0] op, input logic [7:0] nb,
                            input logic [3:0] prd, input logic tst);
    int gap;
    if (burst_left <= 0) begin
      gap = tx_gaps ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, tst, prd, nb, op};
    do @(posedge clk); while (!s_tready);
    execute_instr(op, nb, prd, tst);
  endtask

  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] addr,
                            input logic [31:0] data, output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_variant(input logic v, input logic [30:0] upper);
    logic [31:0] rd;
    wait_results_done();
    apb_access(1'b1, ncis_pkg::ADDR_VARIANT, {upper, v}, rd);
    variant_q = v;
    apb_access(1'b0, ncis_pkg::ADDR_VARIANT, '0, rd);
    if (rd[0] !== v) report_mismatch("cpu_variant readback", rd, {31'd0, v});
  endtask

  function automatic logic [7:0] pick_opcode();
    logic [3:0] lo;
    lo = 4'($urandom);
    if ($urandom_range(0, 99) < 12) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 11))
      0:  return {ncis_pkg::ROW_JCN, lo};
      1:  return {ncis_pkg::ROW_FIM, lo};
      2:  return {ncis_pkg::ROW_JUN, lo};
      3:  return {ncis_pkg::ROW_JMS, lo};
      4:  return {ncis_pkg::ROW_INC, lo};
      5:  return {ncis_pkg::ROW_ADD, lo};
      6:  return {ncis_pkg::ROW_LD, lo};
      7:  return {ncis_pkg::ROW_XCH, lo};
      8:  return {ncis_pkg::ROW_BBL, lo};
      9:  return {ncis_pkg::ROW_LDM, lo};
      10: return {ncis_pkg::ROW_IO, ($urandom_range(0, 1) != 0) ?
                  ncis_pkg::IO_WMP : ncis_pkg::IO_RDR};
      default: begin
        case ($urandom_range(0, 4))
          0: return {ncis_pkg::ROW_ACC, ncis_pkg::ACC_CLB};
          1: return {ncis_pkg::ROW_ACC, ncis_pkg::ACC_CLC};
          2: return {ncis_pkg::ROW_ACC, ncis_pkg::ACC_RAL};
          3: return {ncis_pkg::ROW_ACC, ncis_pkg::ACC_RAR};
          default: return {ncis_pkg::ROW_ACC, ncis_pkg::ACC_DAC};
        endcase
      end
    endcase
  endfunction

  task automatic send_random(input int count);
    repeat (count)
      send_instr(pick_opcode(), 8'($urandom), 4'($urandom), 1'($urandom));
  endtask

  task automatic test_directed_ops();
    send_instr({ncis_pkg::ROW_LDM, 4'h0}, 8'h00, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_FIM, 4'h0}, 8'hFF, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_FIM, 4'h1}, 8'h00, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_INC, 4'h1}, 8'h00, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_LD, 4'h0}, 8'h00, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_ADD, 4'h0}, 8'h00, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_ADD, 4'h1}, 8'h00, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_XCH, 4'h3}, 8'h00, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_JCN, 4'h4}, 8'h80, 4'h0, 1'b1);
    send_instr({ncis_pkg::ROW_JCN, 4'h2}, 8'h40, 4'h0, 1'b1);
    send_instr({ncis_pkg::ROW_JCN, 4'h9}, 8'h33, 4'h0, 1'b1);
    send_instr({ncis_pkg::ROW_ACC, ncis_pkg::ACC_CLC}, 8'h00, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_LDM, 4'hF}, 8'h00, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_ACC, ncis_pkg::ACC_RAL}, 8'h00, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_ACC, ncis_pkg::ACC_RAR}, 8'h00, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_ACC, ncis_pkg::ACC_DAC}, 8'h00, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_IO, ncis_pkg::IO_WMP}, 8'h00, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_IO, ncis_pkg::IO_RDR}, 8'h00, 4'hF, 1'b0);
    send_instr({ncis_pkg::ROW_ACC, ncis_pkg::ACC_CLB}, 8'h00, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_ACC, ncis_pkg::ACC_DAC}, 8'h00, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_JUN, 4'hF}, 8'hFF, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_JCN, 4'h8}, 8'hC3, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_JMS, 4'hA}, 8'h55, 4'h0, 1'b0);
    send_instr({ncis_pkg::ROW_BBL, 4'h7}, 8'h00, 4'h0, 1'b0);
    // unhandled rows and subcodes
    send_instr(8'h00, 8'hFF, 4'hF, 1'b1);
    send_instr(8'h3F, 8'h00, 4'h0, 1'b0);
    send_instr(8'h7A, 8'h00, 4'h0, 1'b0);
    send_instr(8'h9C, 8'h00, 4'h0, 1'b0);
    send_instr(8'hE5, 8'h00, 4'h0, 1'b0);
    send_instr(8'hFF, 8'h00, 4'h0, 1'b0);
  endtask

  task automatic test_stack_wrap();
    write_variant(1'b1, 31'h7FFF_FFFF);
    repeat (9) send_instr({ncis_pkg::ROW_JMS, 4'($urandom)}, 8'($urandom), 4'h0, 1'b0);
    repeat (3) send_instr({ncis_pkg::ROW_BBL, 4'($urandom)}, 8'h00, 4'h0, 1'b0);
    // pointer now beyond the 4-deep range
    write_variant(1'b0, 31'd0);
    repeat (3) send_instr({ncis_pkg::ROW_JMS, 4'($urandom)}, 8'($urandom), 4'h0, 1'b0);
    repeat (5) send_instr({ncis_pkg::ROW_BBL, 4'($urandom)}, 8'h00, 4'h0, 1'b0);
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    hold_req = 300;
    hold_seq++;
    send_random(60);
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_phases();
    write_variant(1'b1, 31'($urandom));
    send_random(300);
    wait_results_done();
    send_random(300);
    write_variant(1'b0, 31'd0);
    tx_gaps = 1'b0;
    rx_free = 1'b1;
    send_random(400);
    tx_gaps = 1'b1;
    rx_free = 1'b0;
    write_variant(1'b1, 31'd0);
    send_random(600);
    write_variant(1'b0, 31'($urandom));
    send_random(400);
  endtask

  always @(posedge clk) begin
    step_result_t got;
    step_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = step_result_t'(m_tdata);
      if (expected_steps.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, '0);
      end else begin
        want = expected_steps.pop_front();
        if (got.pc !== want.pc) report_mismatch("next_pc", got.pc, want.pc);
        if (got.acc !== want.acc) report_mismatch("acc_value", got.acc, want.acc);
        if (got.cy !== want.cy) report_mismatch("carry_value", got.cy, want.cy);
        if (got.port_wr !== want.port_wr)
          report_mismatch("port_write", got.port_wr, want.port_wr);
        if (got.port_addr !== want.port_addr)
          report_mismatch("port_address", got.port_addr, want.port_addr);
        if (got.port_wdata !== want.port_wdata)
          report_mismatch("port_write_data", got.port_wdata, want.port_wdata);
        if (got.illegal !== want.illegal)
          report_mismatch("illegal_op", got.illegal, want.illegal);
        if (got.pad !== 1'b0) report_mismatch("m_tdata[31]", got.pad, 1'b0);
      end
    end
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_req;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_free) begin
      m_tready <= 1'b1;
    end else begin
      if (rx_phase >= rx_period) begin
        rx_phase  = 0;
        rx_period = $urandom_range(2, 12);
        rx_low    = $urandom_range(0, rx_period - 1);
      end
      m_tready <= (rx_phase >= rx_low);
      rx_phase++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors      = 0;
    burst_left  = 0;
    tx_gaps     = 1'b1;
    rx_free     = 1'b0;
    hold_req    = 0;
    hold_seq    = 0;
    reset_shadow();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_ops();
    test_stack_wrap();
    test_backpressure();
    test_random_phases();
    wait_results_done();
    repeat (10) @(posedge clk);
    if (expected_steps.size() != 0)
      report_mismatch("results left over", expected_steps.size(), '0);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
